// ----- rtl/pmul_pkg.sv -----
package pmul_pkg;

	// Operand sizes.
	localparam int MAX_TERMS  = 8;
	localparam int PROD_TERMS = 2 * MAX_TERMS - 1;
	localparam int IDX_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int LEN_W      = $clog2(MAX_TERMS + 1);
	localparam int K_W        = (PROD_TERMS > 1) ? $clog2(PROD_TERMS) : 1;
	localparam int KX_W       = K_W + 1;

	// Data widths.
	localparam int COEFF_W = 32;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = 2 * COEFF_W;
	localparam int ACC_W   = PROD_W + IDX_W + 1;
	localparam int POWER_W = 4;

	// Top bit of the Q16.16 field inside the accumulator.
	localparam int VAL_MSB = FRAC_W + COEFF_W - 1;

	// Load command codes.
	localparam logic CMD_LOAD_A = 1'b0;
	localparam logic CMD_LOAD_B = 1'b1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

endpackage

// ----- rtl/polynomial_multiply.sv -----
// The beat that completes the second operand starts a multiply that computes na*nb
// products on the single shared multiplier (one product per cycle, column by column),
// then drains the pipeline. Results then leave at one beat per cycle while out_stall
// is low, deg+1 beats, and the block is not ready until the last one is taken.
// Reset clears the lengths, completion flags and state.
module polynomial_multiply (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               cmd,
	input  logic signed [pmul_pkg::COEFF_W-1:0] coeff_in,
	input  logic                               last_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [pmul_pkg::COEFF_W-1:0] coeff_out,
	output logic        [pmul_pkg::POWER_W-1:0] power,
	output logic        [pmul_pkg::POWER_W-1:0] result_degree,
	output logic                               all_zero,
	output logic                               saturated,
	output logic                               last_out
);

	pmul_pkg::state_t state_q;

	logic [pmul_pkg::COEFF_W-1:0] a_terms_q [pmul_pkg::MAX_TERMS];
	logic [pmul_pkg::COEFF_W-1:0] b_terms_q [pmul_pkg::MAX_TERMS];
	logic [pmul_pkg::LEN_W-1:0]   a_len_q, b_len_q;
	logic                         a_done_q, b_done_q;

	logic [pmul_pkg::K_W-1:0] k_q, i_q, e_q;
	logic [pmul_pkg::K_W-1:0] deg_q;
	logic                     any_q;

	logic signed [pmul_pkg::PROD_W-1:0] prod_s1;
	logic                               valid_s1, first_s1, last_s1;
	logic [pmul_pkg::K_W-1:0]           k_s1;
	logic signed [pmul_pkg::ACC_W-1:0]  acc_q;
	logic                               fin_s2;
	logic [pmul_pkg::K_W-1:0]           k_s2;

	logic [pmul_pkg::COEFF_W-1:0] vals_q [pmul_pkg::PROD_TERMS];
	logic                         sat_q  [pmul_pkg::PROD_TERMS];

	// Column bounds: first and last index of A that pair with a valid index of B.
	function automatic logic [pmul_pkg::K_W-1:0] col_start(
		input logic [pmul_pkg::K_W-1:0]   k,
		input logic [pmul_pkg::LEN_W-1:0] bl
	);
		logic [pmul_pkg::KX_W-1:0] kx, bx;
		kx = pmul_pkg::KX_W'(k);
		bx = pmul_pkg::KX_W'(bl);
		if (kx >= bx) begin
			return pmul_pkg::K_W'(kx - bx + pmul_pkg::KX_W'(1));
		end
		return '0;
	endfunction

	function automatic logic [pmul_pkg::K_W-1:0] col_end(
		input logic [pmul_pkg::K_W-1:0]   k,
		input logic [pmul_pkg::LEN_W-1:0] al
	);
		logic [pmul_pkg::KX_W-1:0] kx, ax;
		kx = pmul_pkg::KX_W'(k);
		ax = pmul_pkg::KX_W'(al);
		if (kx < ax) begin
			return k;
		end
		return pmul_pkg::K_W'(ax - pmul_pkg::KX_W'(1));
	endfunction

	// Handshake decode.
	logic in_acc, out_acc;
	assign in_stall  = (state_q != pmul_pkg::ST_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == pmul_pkg::ST_EMIT);
	assign out_acc   = out_valid && !out_stall;

	// Operand loading: a beat into a complete operand restarts it while the other one
	// is still open; beats beyond the capacity are dropped, but last still completes.
	logic                       sel_b, x_done, y_done, restart, x_done_n, wr_en;
	logic [pmul_pkg::LEN_W-1:0] x_len, len_eff, len_n;
	logic                       a_done_n, b_done_n, trigger;

	always_comb begin
		sel_b    = (cmd == pmul_pkg::CMD_LOAD_B);
		x_done   = sel_b ? b_done_q : a_done_q;
		y_done   = sel_b ? a_done_q : b_done_q;
		x_len    = sel_b ? b_len_q : a_len_q;
		restart  = x_done && !y_done;
		len_eff  = restart ? '0 : x_len;
		wr_en    = !(x_done && !restart) && (len_eff < pmul_pkg::LEN_W'(pmul_pkg::MAX_TERMS));
		len_n    = wr_en ? len_eff + pmul_pkg::LEN_W'(1) : len_eff;
		x_done_n = (x_done && !restart) || last_in;
		a_done_n = sel_b ? a_done_q : x_done_n;
		b_done_n = sel_b ? x_done_n : b_done_q;
		trigger  = a_done_n && b_done_n;
	end

	// Pair indices for the multiplier.
	logic [pmul_pkg::K_W-1:0] i_first, i_last, j_cur, k_max, k_next;
	always_comb begin
		i_first = col_start(k_q, b_len_q);
		i_last  = col_end(k_q, a_len_q);
		j_cur   = k_q - i_q;
		k_max   = pmul_pkg::K_W'(pmul_pkg::KX_W'(a_len_q) + pmul_pkg::KX_W'(b_len_q)
			- pmul_pkg::KX_W'(2));
		k_next  = k_q + pmul_pkg::K_W'(1);
	end

	// Sequencer and operand control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pmul_pkg::ST_LOAD;
			a_len_q  <= '0;
			b_len_q  <= '0;
			a_done_q <= 1'b0;
			b_done_q <= 1'b0;
			k_q      <= '0;
			i_q      <= '0;
			e_q      <= '0;
		end else begin
			case (state_q)
				pmul_pkg::ST_LOAD: begin
					if (in_acc) begin
						if (sel_b) begin
							b_len_q <= len_n;
						end else begin
							a_len_q <= len_n;
						end
						a_done_q <= a_done_n;
						b_done_q <= b_done_n;
						if (trigger) begin
							state_q <= pmul_pkg::ST_MAC;
							k_q     <= '0;
							i_q     <= '0;
						end
					end
				end
				pmul_pkg::ST_MAC: begin
					if (i_q == i_last) begin
						if (k_q == k_max) begin
							state_q <= pmul_pkg::ST_DRAIN;
						end else begin
							k_q <= k_next;
							i_q <= col_start(k_next, b_len_q);
						end
					end else begin
						i_q <= i_q + pmul_pkg::K_W'(1);
					end
				end
				pmul_pkg::ST_DRAIN: begin
					if (!valid_s1 && !fin_s2) begin
						state_q <= pmul_pkg::ST_EMIT;
						e_q     <= '0;
					end
				end
				pmul_pkg::ST_EMIT: begin
					if (out_acc) begin
						if (e_q == deg_q) begin
							state_q  <= pmul_pkg::ST_LOAD;
							a_len_q  <= '0;
							b_len_q  <= '0;
							a_done_q <= 1'b0;
							b_done_q <= 1'b0;
						end else begin
							e_q <= e_q + pmul_pkg::K_W'(1);
						end
					end
				end
				default: begin
					state_q <= pmul_pkg::ST_LOAD;
				end
			endcase
		end
	end

	// Coefficient storage.
	always_ff @(posedge clk) begin
		if (in_acc && wr_en) begin
			if (sel_b) begin
				b_terms_q[len_eff[pmul_pkg::IDX_W-1:0]] <= coeff_in;
			end else begin
				a_terms_q[len_eff[pmul_pkg::IDX_W-1:0]] <= coeff_in;
			end
		end
	end

	// Pipeline control bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fin_s2   <= 1'b0;
		end else begin
			valid_s1 <= (state_q == pmul_pkg::ST_MAC);
			fin_s2   <= valid_s1 && last_s1;
		end
	end

	// Stage 1: one exact product per cycle on the shared multiplier.
	always_ff @(posedge clk) begin
		prod_s1  <= $signed(a_terms_q[i_q[pmul_pkg::IDX_W-1:0]])
			* $signed(b_terms_q[j_cur[pmul_pkg::IDX_W-1:0]]);
		first_s1 <= (i_q == i_first);
		last_s1  <= (i_q == i_last);
		k_s1     <= k_q;
	end

	// Stage 2: column accumulation at full precision.
	logic signed [pmul_pkg::ACC_W-1:0] prod_ext;
	assign prod_ext = {{(pmul_pkg::ACC_W - pmul_pkg::PROD_W){prod_s1[pmul_pkg::PROD_W-1]}},
		prod_s1};

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_q <= first_s1 ? prod_ext : acc_q + prod_ext;
		end
		k_s2 <= k_s1;
	end

	// Stage 3: floor to Q16.16 and saturate a finished column.
	logic [pmul_pkg::ACC_W-pmul_pkg::VAL_MSB-1:0] acc_top;
	logic                                         col_ovf;
	logic [pmul_pkg::COEFF_W-1:0]                 col_val;
	assign acc_top = acc_q[pmul_pkg::ACC_W-1:pmul_pkg::VAL_MSB];

	always_comb begin
		col_ovf = !((&acc_top) || !(|acc_top));
		if (col_ovf) begin
			col_val = acc_q[pmul_pkg::ACC_W-1]
				? {1'b1, {(pmul_pkg::COEFF_W - 1){1'b0}}}
				: {1'b0, {(pmul_pkg::COEFF_W - 1){1'b1}}};
		end else begin
			col_val = acc_q[pmul_pkg::VAL_MSB:pmul_pkg::FRAC_W];
		end
	end

	always_ff @(posedge clk) begin
		if (fin_s2) begin
			vals_q[k_s2] <= col_val;
			sat_q[k_s2]  <= col_ovf;
		end
	end

	// Degree tracking: columns finish in ascending order, so the last nonzero wins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= '0;
			any_q <= 1'b0;
		end else begin
			if (in_acc && trigger) begin
				deg_q <= '0;
				any_q <= 1'b0;
			end else if (fin_s2 && (col_val != '0)) begin
				deg_q <= k_s2;
				any_q <= 1'b1;
			end
		end
	end

	// Result beats.
	assign coeff_out     = vals_q[e_q];
	assign saturated     = sat_q[e_q];
	assign power         = pmul_pkg::POWER_W'(e_q);
	assign result_degree = pmul_pkg::POWER_W'(deg_q);
	assign all_zero      = !any_q;
	assign last_out      = (e_q == deg_q);

endmodule
